### sv/tpd_pkg.sv
package tpd_pkg;

  // Field widths.
  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 12;
  localparam int PRESS_W    = 8;
  localparam int TWIDTH_W   = 4;
  localparam int FINGER_W   = 2;
  localparam int PKT_LEN    = 6;
  localparam int POS_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 1'd1;

  // Reset value of the Y limit.
  localparam logic [COORD_W-1:0] Y_LIMIT_RESET = 12'hfff;

  // Positions of the first and last bytes of a packet.
  localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
  localparam logic [POS_W-1:0] POS_LAST  = 3'(PKT_LEN - 1);

  // Finger counts: none, and two, which marks the two-finger head/tail pairing.
  localparam logic [FINGER_W-1:0] FINGERS_NONE = 2'd0;
  localparam logic [FINGER_W-1:0] FINGERS_TWO  = 2'd2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t [PKT_LEN-1:0] packet_t;

  // Debounce packet C4 FF FF 02 FF FF, byte 0 in the low slot.
  localparam packet_t DEBOUNCE_SIG = {8'hff, 8'hff, 8'h02, 8'hff, 8'hff, 8'hc4};

  // Packet type signatures on bytes 0 and 3.
  localparam byte_t B0_SIG_MASK   = 8'h0c;
  localparam byte_t B0_HEAD_SIG   = 8'h04;
  localparam byte_t B0_TAIL_SIG   = 8'h0c;
  localparam byte_t B3_HEAD_MASK  = 8'hcf;
  localparam byte_t B3_HEAD_SIG   = 8'h02;
  localparam byte_t B3_TAIL_MASK  = 8'hce;
  localparam byte_t B3_TAIL_SIG   = 8'h0c;

  typedef struct packed {
    logic [FINGER_W-1:0] finger_count;
    logic [COORD_W-1:0]  first_x;
    logic [COORD_W-1:0]  first_y;
    logic [COORD_W-1:0]  second_x;
    logic [COORD_W-1:0]  second_y;
    logic [PRESS_W-1:0]  pressure;
    logic [TWIDTH_W-1:0] tool_width;
    logic                button_left;
    logic                button_right;
  } result_t;

  // Decoder control toward the top level.
  typedef struct packed {
    logic               emit;
    logic               store_head;
    logic [COORD_W-1:0] head_x;
    logic [COORD_W-1:0] head_y;
  } dec_ctl_t;

  // Mirror a raw Y against the limit, saturating at zero.
  function automatic logic [COORD_W-1:0] mirror_y(input logic [COORD_W-1:0] raw,
                                                  input logic [COORD_W-1:0] limit);
    logic [COORD_W-1:0] res;
    if (raw > limit) begin
      res = '0;
    end else begin
      res = limit - raw;
    end
    return res;
  endfunction

endpackage

### sv/tpd_byte_if.sv
interface tpd_byte_if import tpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  logic              resync;

  modport source (output valid, output stream_byte, output resync, input ready);
  modport sink (input valid, input stream_byte, input resync, output ready);
endinterface

### sv/tpd_result_if.sv
interface tpd_result_if import tpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FINGER_W-1:0] finger_count;
  logic [COORD_W-1:0]  first_x;
  logic [COORD_W-1:0]  first_y;
  logic [COORD_W-1:0]  second_x;
  logic [COORD_W-1:0]  second_y;
  logic [PRESS_W-1:0]  pressure;
  logic [TWIDTH_W-1:0] tool_width;
  logic                button_left;
  logic                button_right;

  modport source (output valid, output finger_count, output first_x, output first_y,
                  output second_x, output second_y, output pressure, output tool_width,
                  output button_left, output button_right, input ready);
  modport sink (input valid, input finger_count, input first_x, input first_y,
                input second_x, input second_y, input pressure, input tool_width,
                input button_left, input button_right, output ready);
endinterface

### sv/touchpad_v3_packet_decoder.sv
// Touchpad packet decoder for six-byte absolute packets with two-finger support.
// Stream bytes enter on byte_in, one per beat, with resync restarting packet
// assembly at the byte that carries it. Decoded reports leave on result_out.
// The configuration port writes enable (index 0) and y_limit (index 1); write
// it only while no packet is in flight.
// Throughput is one byte per cycle while byte_in.ready stays high, which it
// does as long as the packet buffer can drain. The report for a packet is
// loaded into the packet register on the beat that carries its sixth byte,
// then into the result register, which drives it onto result_out.
// Debounce, unknown and two-finger head packets give no report; a
// two-finger head stores the first finger for the tail that follows.
// When the receiver stalls, the result register holds its report and the
// packet register holds one more complete packet; byte_in.ready then stays low
// until the packet register can pass its packet on to the result register,
// whichever byte of the next packet is being offered.
// Reset clears the byte position, the held first finger, enable (decoding
// off) and sets y_limit to 4095; no report is pending after reset.
module touchpad_v3_packet_decoder import tpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tpd_byte_if.sink              byte_in,
  tpd_result_if.source          result_out
);

  logic               enable;
  logic [COORD_W-1:0] y_limit;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_eff;
  byte_t              hold_bytes [PKT_LEN-1];
  packet_t            pkt;
  logic               pkt_valid;
  logic               out_valid;
  result_t            out_res;
  logic [COORD_W-1:0] held_x;
  logic [COORD_W-1:0] held_y;
  logic               byte_acc;
  logic               complete;
  logic               adv;
  dec_ctl_t           ctl;
  result_t            res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b0;
      y_limit <= Y_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:  enable  <= cfg_data[0];
        REG_Y_LIMIT: y_limit <= cfg_data[COORD_W-1:0];
        default:     ;
      endcase
    end
  end

  // Handshake and pipeline advance.
  assign adv            = pkt_valid && (!out_valid || result_out.ready);
  assign byte_in.ready  = !pkt_valid || adv;
  assign byte_acc       = byte_in.valid && byte_in.ready;
  assign pos_eff        = byte_in.resync ? POS_FIRST : pos;
  assign complete       = byte_acc && (pos_eff == POS_LAST);

  // Byte position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_FIRST;
    end else if (byte_acc) begin
      pos <= complete ? POS_FIRST : pos_eff + 3'd1;
    end
  end

  // Partial packet storage for the first five bytes.
  always_ff @(posedge clk) begin
    if (byte_acc && !complete) begin
      hold_bytes[pos_eff] <= byte_in.stream_byte;
    end
  end

  // Packet register, loaded on the sixth byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else if (complete) begin
      pkt_valid <= 1'b1;
    end else if (adv) begin
      pkt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      pkt <= {byte_in.stream_byte, hold_bytes[4], hold_bytes[3], hold_bytes[2],
              hold_bytes[1], hold_bytes[0]};
    end
  end

  tpd_decode u_decode (
    .pkt     (pkt),
    .y_limit (y_limit),
    .held_x  (held_x),
    .held_y  (held_y),
    .ctl     (ctl),
    .res     (res)
  );

  // Held first finger from a two-finger head packet.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_x <= '0;
      held_y <= '0;
    end else if (adv && enable && ctl.store_head) begin
      held_x <= ctl.head_x;
      held_y <= ctl.head_y;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && enable && ctl.emit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && enable && ctl.emit) begin
      out_res <= res;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.finger_count = out_res.finger_count;
  assign result_out.first_x      = out_res.first_x;
  assign result_out.first_y      = out_res.first_y;
  assign result_out.second_x     = out_res.second_x;
  assign result_out.second_y     = out_res.second_y;
  assign result_out.pressure     = out_res.pressure;
  assign result_out.tool_width   = out_res.tool_width;
  assign result_out.button_left  = out_res.button_left;
  assign result_out.button_right = out_res.button_right;

  // The byte position never leaves the packet.
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_LAST)
    else $error("byte position out of range");

  // A completed packet is always captured for decoding.
  a_pkt_capture: assert property (@(posedge clk) disable iff (rst)
    complete |=> pkt_valid)
    else $error("completed packet not captured");

  // A new report only comes from a buffered packet.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pkt_valid) && $past(enable))
    else $error("report without a buffered packet");

  // The held finger changes only on an enabled two-finger head.
  a_held_update: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && (!$stable(held_x) || !$stable(held_y)) |->
      $past(adv && enable && ctl.store_head))
    else $error("held finger changed without a head packet");

endmodule

### sv/tpd_decode.sv
module tpd_decode import tpd_pkg::*; (
  input  packet_t            pkt,
  input  logic [COORD_W-1:0] y_limit,
  input  logic [COORD_W-1:0] held_x,
  input  logic [COORD_W-1:0] held_y,
  output dec_ctl_t           ctl,
  output result_t            res
);

  logic                is_debounce;
  logic                is_head;
  logic                is_tail;
  logic                known;
  logic [FINGER_W-1:0] fingers;
  logic [COORD_W-1:0]  pkt_x;
  logic [COORD_W-1:0]  pkt_y;

  // Classify the packet.
  assign is_debounce = (pkt == DEBOUNCE_SIG);
  assign is_head = ((pkt[0] & B0_SIG_MASK) == B0_HEAD_SIG) &&
                   ((pkt[3] & B3_HEAD_MASK) == B3_HEAD_SIG);
  assign is_tail = ((pkt[0] & B0_SIG_MASK) == B0_TAIL_SIG) &&
                   ((pkt[3] & B3_TAIL_MASK) == B3_TAIL_SIG);
  assign known   = !is_debounce && (is_head || is_tail);
  assign fingers = pkt[0][7:6];

  // Position carried in the packet, Y mirrored.
  assign pkt_x = {pkt[1][3:0], pkt[2]};
  assign pkt_y = mirror_y({pkt[4][3:0], pkt[5]}, y_limit);

  // A two-finger head only updates the held first finger.
  always_comb begin
    ctl.store_head = known && is_head && (fingers == FINGERS_TWO);
    ctl.emit       = known && !ctl.store_head;
    ctl.head_x     = pkt_x;
    ctl.head_y     = pkt_y;
  end

  // Assemble the result fields.
  always_comb begin
    res.finger_count = fingers;
    res.first_x      = '0;
    res.first_y      = '0;
    res.second_x     = '0;
    res.second_y     = '0;
    if (fingers == FINGERS_TWO) begin
      res.first_x  = held_x;
      res.first_y  = held_y;
      res.second_x = pkt_x;
      res.second_y = pkt_y;
    end else if (fingers != FINGERS_NONE) begin
      res.first_x = pkt_x;
      res.first_y = pkt_y;
    end
    res.pressure     = {pkt[1][7:4], pkt[4][7:4]};
    res.tool_width   = {pkt[0][5:4], pkt[3][5:4]};
    res.button_left  = pkt[0][0];
    res.button_right = pkt[0][1];
  end

endmodule
